// ----- rtl/frf_pkg.sv -----
`default_nettype none
package frf_pkg;

    localparam logic [1:0]  ST_EVAL       = 2'd0;
    localparam logic [1:0]  ST_ROOT       = 2'd1;
    localparam logic [1:0]  ST_INVALID    = 2'd2;
    localparam logic [1:0]  ST_IDLE       = 2'd3;

    localparam logic        MODE_START    = 1'b0;

    localparam logic        CFG_WIDTH_TOL = 1'b0;
    localparam logic        CFG_VALUE_TOL = 1'b1;

    localparam logic [30:0] TOL_RESET     = 31'd66;
    localparam logic [30:0] ERR_MAX       = 31'h7FFF_FFFF;
    localparam logic [6:0]  PERCENT       = 7'd100;
    localparam logic [5:0]  DIV_LAST      = 6'd63;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] left_end;
        logic signed [31:0] right_end;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic signed [31:0] probe_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] point;
        logic [30:0]        rel_error_pct;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ERR_MUL,
        S_ERR_GO,
        S_ERR_DIV,
        S_PROBE_UPD,
        S_WIDTH,
        S_SEC_PREP,
        S_SEC_MUL,
        S_SEC_GO,
        S_SEC_DIV,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_RES_INVALID,
        OP_RES_MID,
        OP_RES_LEFT,
        OP_RES_RIGHT,
        OP_RES_IDLE,
        OP_LOAD_BRACKET,
        OP_ERR_PREP,
        OP_ERR_MUL,
        OP_DIV_GO,
        OP_ERR_TAKE,
        OP_RES_ROOT,
        OP_UPDATE,
        OP_SET_PREV,
        OP_RES_ZERO_DEN,
        OP_SEC_PREP,
        OP_SEC_MUL,
        OP_SEC_TAKE
    } t_dp_op;

    typedef struct packed {
        logic is_start;
        logic searching;
        logic invalid;
        logic narrow_start;
        logic fa_small;
        logic fb_small;
        logic ax_zero;
        logic fx_small;
        logic width_narrow;
        logic den_zero;
        logic div_done;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- rtl/false_position_root_finder.sv -----
// False-position root finder in signed Q16.16 fixed point.
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one
// transaction per item. A start transaction (mode 0) brings a bracket and the
// function values at its ends; a probe transaction (mode 1) brings the
// function value at the point the block last requested.
// Every input transaction produces exactly one output transaction on
// o_out_valid / i_out_ready / o_out_data: a point to evaluate, a root, an
// invalid-bracket report, or a zero-denominator or idle report.
// Items are handled one at a time. A start either ends at once or computes a
// secant point. A probe may compute both the relative change and the secant
// point; each goes through the shared 64-step restoring divider, which sets the
// rate.
// While a result waits for the receiver the block holds it and does not take
// a new input transaction; o_in_ready is high only when the block is empty.
// Both tolerances reset to 66. The user writes them through i_cfg_we, i_cfg_idx
// and i_cfg_data only while the block is idle; the block does not enforce it.
// Synchronous active-low reset returns the block to idle with no search in progress.
`default_nettype none
module false_position_root_finder
    import frf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    t_dp_op     w_op;
    t_dp_status w_status;

    // The controller sequences each transaction; the datapath holds the
    // bracket, the tolerances and the divider.
    frf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_op        (w_op)
    );

    frf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_data     (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (w_status),
        .o_result   (o_out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/frf_div.sv -----
`default_nettype none
module frf_div
    import frf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [32:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);

    // Restoring division, one quotient bit per cycle.
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [33:0] w_sh;
    logic        w_fit;
    logic [33:0] w_diff;

    assign w_sh   = {r_rem, r_q[63]};
    assign w_fit  = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], w_fit};
            r_rem <= w_fit ? w_diff[32:0] : w_sh[32:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

// ----- rtl/frf_datapath.sv -----
`default_nettype none
module frf_datapath
    import frf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_op      i_op,
    input  wire t_in         i_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [30:0] i_cfg_data,
    output t_dp_status       o_status,
    output t_out             o_result
);

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'd0 - v : v;
    endfunction

    t_in                r_in;
    logic signed [31:0] r_le, r_he, r_lv, r_hv, r_cur, r_prev;
    logic               r_lsp, r_searching, r_neg;
    logic [30:0]        r_wt, r_vt, r_err;
    logic [32:0]        r_d, r_dvs;
    logic [31:0]        r_ax, r_ma, r_mb;
    logic [63:0]        r_dvd;
    t_out               r_res;

    logic               w_div_done;
    logic [63:0]        w_q;

    frf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_op == OP_DIV_GO),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_q)
    );

    logic signed [31:0] fa, fb, a, b, fx;
    logic signed [32:0] w_span_in, w_mid_sum, w_mid, w_span, w_den, w_diff;
    logic               w_move_low;
    logic [39:0]        w_d100;
    logic signed [65:0] w_qs, w_sum;
    logic signed [31:0] w_x;

    always_comb begin
        a  = r_in.left_end;
        b  = r_in.right_end;
        fa = r_in.left_value;
        fb = r_in.right_value;
        fx = r_in.probe_value;
        w_span_in = {b[31], b} - {a[31], a};
        w_mid_sum = {a[31], a} + {b[31], b};
        w_mid     = (w_mid_sum + {32'd0, w_mid_sum[32]}) >>> 1;
        w_span    = {r_he[31], r_he} - {r_le[31], r_le};
        w_den     = {r_hv[31], r_hv} - {r_lv[31], r_lv};
        w_diff    = {r_cur[31], r_cur} - {r_prev[31], r_prev};
        w_move_low = r_lsp ? (fx > 0) : (fx < 0);
        w_d100    = r_d * PERCENT;
        w_qs      = r_neg ? 66'sd0 - $signed({2'b00, w_q}) : $signed({2'b00, w_q});
        w_sum     = {{34{r_le[31]}}, r_le} + w_qs;
        if (w_sum[65:31] == {35{1'b0}} || w_sum[65:31] == {35{1'b1}}) begin
            w_x = w_sum[31:0];
        end else begin
            w_x = w_sum[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_comb begin
        o_status.is_start     = r_in.mode == MODE_START;
        o_status.searching    = r_searching;
        o_status.invalid      = ((fa > 0) && (fb > 0)) || ((fa < 0) && (fb < 0)) || (a > b);
        o_status.narrow_start = w_span_in < $signed({2'b00, r_wt});
        o_status.fa_small     = mag32(fa) < {1'b0, r_vt};
        o_status.fb_small     = mag32(fb) < {1'b0, r_vt};
        o_status.ax_zero      = r_ax == 32'd0;
        o_status.fx_small     = mag32(fx) < {1'b0, r_vt};
        o_status.width_narrow = w_span < $signed({2'b00, r_wt});
        o_status.den_zero     = r_hv == r_lv;
        o_status.div_done     = w_div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt        <= TOL_RESET;
            r_vt        <= TOL_RESET;
            r_searching <= 1'b0;
            r_le        <= '0;
            r_he        <= '0;
            r_lv        <= '0;
            r_hv        <= '0;
            r_lsp       <= 1'b0;
            r_cur       <= '0;
            r_prev      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH_TOL: r_wt <= i_cfg_data;
                    CFG_VALUE_TOL: r_vt <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_op)
                OP_CAPTURE: begin
                    if (i_data.mode == MODE_START) begin
                        r_searching <= 1'b0;
                    end
                end
                OP_LOAD_BRACKET: begin
                    r_le   <= a;
                    r_he   <= b;
                    r_lv   <= fa;
                    r_hv   <= fb;
                    r_lsp  <= fa > 0;
                    r_prev <= a;
                end
                OP_RES_ROOT, OP_RES_ZERO_DEN: r_searching <= 1'b0;
                OP_UPDATE: begin
                    if (w_move_low) begin
                        r_le <= r_cur;
                        r_lv <= fx;
                    end else begin
                        r_he <= r_cur;
                        r_hv <= fx;
                    end
                end
                OP_SET_PREV: r_prev <= r_cur;
                OP_SEC_TAKE: begin
                    r_cur       <= w_x;
                    r_searching <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_CAPTURE:      r_in <= i_data;
            OP_RES_INVALID:  r_res <= '{ST_INVALID, 32'sd0, 31'd0};
            OP_RES_MID:      r_res <= '{ST_ROOT, w_mid[31:0], 31'd0};
            OP_RES_LEFT:     r_res <= '{ST_ROOT, a, 31'd0};
            OP_RES_RIGHT:    r_res <= '{ST_ROOT, b, 31'd0};
            OP_RES_IDLE:     r_res <= '{ST_IDLE, 32'sd0, 31'd0};
            OP_LOAD_BRACKET: r_err <= '0;
            OP_ERR_PREP: begin
                r_d  <= mag33(w_diff);
                r_ax <= mag32(r_cur);
            end
            OP_ERR_MUL: begin
                r_dvd <= {8'd0, w_d100, 16'd0};
                r_dvs <= {1'b0, r_ax};
                r_err <= (r_d == 33'd0) ? 31'd0 : ERR_MAX;
            end
            OP_ERR_TAKE:     r_err <= (w_q[63:31] != 33'd0) ? ERR_MAX : w_q[30:0];
            OP_RES_ROOT:     r_res <= '{ST_ROOT, r_cur, r_err};
            OP_RES_ZERO_DEN: r_res <= '{ST_IDLE, 32'sd0, r_err};
            OP_SEC_PREP: begin
                // The span is never negative here: a negative span ends the
                // search as a narrow bracket before a secant point is needed.
                r_ma  <= mag32(r_lv);
                r_mb  <= w_span[31:0];
                r_dvs <= mag33(w_den);
                r_neg <= (r_lv > 0) ^ w_span[32] ^ w_den[32];
            end
            OP_SEC_MUL:      r_dvd <= r_ma * r_mb;
            OP_SEC_TAKE:     r_res <= '{ST_EVAL, w_x, r_err};
            default: ;
        endcase
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

// ----- rtl/frf_ctrl.sv -----
`default_nettype none
module frf_ctrl
    import frf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_dp_op          o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_status.is_start) begin
                    if (i_status.invalid || i_status.narrow_start
                            || i_status.fa_small || i_status.fb_small) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SEC_PREP;
                    end
                end else begin
                    n_state = i_status.searching ? S_ERR_MUL : S_OUT;
                end
            end
            S_ERR_MUL:   n_state = i_status.ax_zero ? S_PROBE_UPD : S_ERR_GO;
            S_ERR_GO:    n_state = S_ERR_DIV;
            S_ERR_DIV:   if (i_status.div_done) n_state = S_PROBE_UPD;
            S_PROBE_UPD: n_state = i_status.fx_small ? S_OUT : S_WIDTH;
            S_WIDTH:     n_state = i_status.width_narrow ? S_OUT : S_SEC_PREP;
            S_SEC_PREP:  n_state = i_status.den_zero ? S_OUT : S_SEC_MUL;
            S_SEC_MUL:   n_state = S_SEC_GO;
            S_SEC_GO:    n_state = S_SEC_DIV;
            S_SEC_DIV:   if (i_status.div_done) n_state = S_OUT;
            S_OUT:       if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op        = OP_NONE;
        o_in_ready  = r_state == S_IDLE;
        o_out_valid = r_state == S_OUT;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) o_op = OP_CAPTURE;
            S_DECODE: begin
                if (i_status.is_start) begin
                    if (i_status.invalid)           o_op = OP_RES_INVALID;
                    else if (i_status.narrow_start) o_op = OP_RES_MID;
                    else if (i_status.fa_small)     o_op = OP_RES_LEFT;
                    else if (i_status.fb_small)     o_op = OP_RES_RIGHT;
                    else                            o_op = OP_LOAD_BRACKET;
                end else begin
                    o_op = i_status.searching ? OP_ERR_PREP : OP_RES_IDLE;
                end
            end
            S_ERR_MUL:   o_op = OP_ERR_MUL;
            S_ERR_GO:    o_op = OP_DIV_GO;
            S_ERR_DIV:   if (i_status.div_done) o_op = OP_ERR_TAKE;
            S_PROBE_UPD: o_op = i_status.fx_small ? OP_RES_ROOT : OP_UPDATE;
            S_WIDTH:     o_op = i_status.width_narrow ? OP_RES_ROOT : OP_SET_PREV;
            S_SEC_PREP:  o_op = i_status.den_zero ? OP_RES_ZERO_DEN : OP_SEC_PREP;
            S_SEC_MUL:   o_op = OP_SEC_MUL;
            S_SEC_GO:    o_op = OP_DIV_GO;
            S_SEC_DIV:   if (i_status.div_done) o_op = OP_SEC_TAKE;
            S_OUT:       o_op = OP_NONE;
            default:     o_op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire
